[hdl/tcce_pkg.sv]
// shared types and constants for the text console cursor engine
package tcce_pkg;

    localparam int CHAR_W  = 8;
    localparam int GRID_W  = 8;
    localparam int PIXEL_W = 13;

    localparam logic [PIXEL_W-1:0] PIXEL_MAX = 13'h1FFF;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7F;
    localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd2;

    // result queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ACT_DRAW   = 1'b0,
        ACT_SCROLL = 1'b1
    } action_t;

    typedef struct packed {
        logic              enable;
        logic [GRID_W-1:0] columns;
        logic [GRID_W-1:0] rows;
    } cfg_t;

    // everything one character produces: an optional draw and an optional scroll
    typedef struct packed {
        logic               draw_en;
        logic               scroll_en;
        logic [PIXEL_W-1:0] pixel_x;
        logic [PIXEL_W-1:0] pixel_y;
        logic [CHAR_W-1:0]  glyph_code;
    } item_res_t;

    typedef struct packed {
        action_t            action;
        logic [PIXEL_W-1:0] pixel_x;
        logic [PIXEL_W-1:0] pixel_y;
        logic [CHAR_W-1:0]  glyph_code;
        logic               last;
    } result_t;

endpackage

[hdl/tcce_step.sv]
// input register, cursor state and per-character cursor update
module tcce_step #(
    parameter int CELL_WIDTH  = 18,
    parameter int CELL_HEIGHT = 18
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tcce_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tcce_pkg::CHAR_W-1:0]  in_char,
    input  logic                         can_push,
    output logic                         push_valid,
    output tcce_pkg::item_res_t          push_data
);

    localparam int XP_RAW = tcce_pkg::GRID_W + $clog2(CELL_WIDTH + 1);
    localparam int YP_RAW = tcce_pkg::GRID_W + $clog2(CELL_HEIGHT + 1);
    localparam int XP_W   = (XP_RAW > tcce_pkg::PIXEL_W) ? XP_RAW : tcce_pkg::PIXEL_W + 1;
    localparam int YP_W   = (YP_RAW > tcce_pkg::PIXEL_W) ? YP_RAW : tcce_pkg::PIXEL_W + 1;

    logic                         hold_valid_reg;
    logic [tcce_pkg::CHAR_W-1:0]  hold_char_reg;
    logic [tcce_pkg::GRID_W-1:0]  row_reg, row_next;
    logic [tcce_pkg::GRID_W-1:0]  col_reg, col_next;

    logic                         active, is_lf, is_cr, is_bs, newline;
    logic                         draw_en, scroll_en, fire;
    logic [tcce_pkg::GRID_W:0]    row_inc, col_inc;
    logic [tcce_pkg::GRID_W-1:0]  draw_col, draw_row;
    logic [tcce_pkg::CHAR_W-1:0]  glyph;
    logic [XP_W-1:0]              x_prod;
    logic [YP_W-1:0]              y_prod;

    assign active = cfg.enable && (cfg.columns != '0) && (cfg.rows != '0);
    assign is_lf  = (hold_char_reg == tcce_pkg::CHAR_LF);
    assign is_cr  = (hold_char_reg == tcce_pkg::CHAR_CR);
    assign is_bs  = (hold_char_reg == tcce_pkg::CHAR_BS) ||
                    (hold_char_reg == tcce_pkg::CHAR_DEL);

    assign row_inc = {1'b0, row_reg} + 9'd1;
    assign col_inc = {1'b0, col_reg} + 9'd1;

    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        draw_en   = 1'b0;
        scroll_en = 1'b0;
        newline   = 1'b0;
        draw_col  = col_reg;
        draw_row  = row_reg;
        glyph     = hold_char_reg;
        if (active) begin
            if (is_lf) begin
                newline = 1'b1;
            end else if (is_cr) begin
                col_next = '0;
            end else if (is_bs) begin
                glyph = tcce_pkg::CHAR_BLANK;
                if (col_reg != '0) begin
                    col_next = col_reg - 8'd1;
                    draw_en  = 1'b1;
                end else if (row_reg != '0) begin
                    row_next = row_reg - 8'd1;
                    col_next = cfg.columns - 8'd1;
                    draw_en  = 1'b1;
                end
                // erase lands on the cell the cursor moved to
                draw_col = col_next;
                draw_row = row_next;
            end else begin
                draw_en = 1'b1;
                if (col_inc >= {1'b0, cfg.columns}) begin
                    newline = 1'b1;
                end else begin
                    col_next = col_inc[tcce_pkg::GRID_W-1:0];
                end
            end
            if (newline) begin
                col_next = '0;
                if (row_inc >= {1'b0, cfg.rows}) begin
                    scroll_en = 1'b1;
                    row_next  = cfg.rows - 8'd1;
                end else begin
                    row_next = row_inc[tcce_pkg::GRID_W-1:0];
                end
            end
        end
    end

    // cell origin in pixels, saturating
    assign x_prod = XP_W'(draw_col) * XP_W'(CELL_WIDTH);
    assign y_prod = YP_W'(draw_row) * YP_W'(CELL_HEIGHT);

    always_comb begin
        push_data.draw_en    = draw_en;
        push_data.scroll_en  = scroll_en;
        push_data.glyph_code = glyph;
        push_data.pixel_x    = (x_prod > XP_W'(tcce_pkg::PIXEL_MAX)) ? tcce_pkg::PIXEL_MAX
                                                                     : x_prod[tcce_pkg::PIXEL_W-1:0];
        push_data.pixel_y    = (y_prod > YP_W'(tcce_pkg::PIXEL_MAX)) ? tcce_pkg::PIXEL_MAX
                                                                     : y_prod[tcce_pkg::PIXEL_W-1:0];
    end

    assign fire       = hold_valid_reg && can_push;
    assign in_ready   = !hold_valid_reg || can_push;
    assign push_valid = fire && (draw_en || scroll_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
        end else begin
            if (in_ready) begin
                hold_valid_reg <= in_valid;
            end
            if (fire) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            hold_char_reg <= in_char;
        end
    end

endmodule

[hdl/tcce_result_queue.sv]
// two-entry queue of per-character results, unrolled into single commands
module tcce_result_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    input  tcce_pkg::item_res_t push_data,
    output logic                can_push,
    output logic                out_valid,
    input  logic                out_ready,
    output tcce_pkg::result_t   out_res
);

    tcce_pkg::item_res_t                  entries_reg [tcce_pkg::QUEUE_DEPTH];
    logic [tcce_pkg::QUEUE_AW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [tcce_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic                                 phase_reg;
    tcce_pkg::item_res_t                  head;
    logic                                 show_draw, pop, xfer;

    assign head      = entries_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign can_push  = (count_reg != tcce_pkg::QUEUE_CNT_W'(tcce_pkg::QUEUE_DEPTH));
    assign show_draw = head.draw_en && !phase_reg;

    always_comb begin
        out_res.action     = show_draw ? tcce_pkg::ACT_DRAW : tcce_pkg::ACT_SCROLL;
        out_res.pixel_x    = show_draw ? head.pixel_x : '0;
        out_res.pixel_y    = show_draw ? head.pixel_y : '0;
        out_res.glyph_code = show_draw ? head.glyph_code : '0;
        out_res.last       = !show_draw || !head.scroll_en;
    end

    assign xfer = out_valid && out_ready;
    assign pop  = xfer && out_res.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (xfer) begin
                phase_reg <= !out_res.last;
            end
            case ({push_valid, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    // occupancy stays within the queue
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= tcce_pkg::QUEUE_CNT_W'(tcce_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    // second half of an entry only exists for draw followed by scroll
    a_phase_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (out_valid && head.draw_en && head.scroll_en))
        else $error("scroll phase without a draw and scroll pair");

    // producer never writes into a full queue
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> can_push)
        else $error("push into full result queue");

    // a write into an empty queue shows up on the next cycle
    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_valid && count_reg == '0) |=> out_valid)
        else $error("pushed result not presented");

endmodule

[hdl/text_console_cursor_engine_top.sv]
// top level of the text console cursor engine
//
// Turns a stream of character bytes into draw and scroll commands for a
// character-cell display while tracking a cursor row and column. Each
// character is registered, processed combinationally against the cursor
// and its commands queued in a two-entry result queue. A new character is
// taken every cycle as long as each produces at most one command and the
// receiver does not stall; a printable character at the end of the last
// row produces a draw and a scroll and holds the result port for both,
// since the port carries one command per cycle. Characters that produce no
// command (carriage return, a newline without scroll, ignored bytes) still
// pass through the input register. Configuration must be written through
// cfg_we/cfg_index/cfg_data while the engine is idle (the block does not
// enforce it); enable off or a zero-size grid drops every byte without output.
module text_console_cursor_engine_top #(
    parameter int CELL_WIDTH  = 18,
    parameter int CELL_HEIGHT = 18
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcce_pkg::GRID_W-1:0]     cfg_data,
    // character input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tcce_pkg::CHAR_W-1:0]     s_char_code,
    // display commands
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_action,
    output logic [tcce_pkg::PIXEL_W-1:0]    m_pixel_x,
    output logic [tcce_pkg::PIXEL_W-1:0]    m_pixel_y,
    output logic [tcce_pkg::CHAR_W-1:0]     m_glyph_code,
    output logic                            m_last
);

    tcce_pkg::cfg_t       cfg_reg;
    tcce_pkg::item_res_t  push_data;
    tcce_pkg::result_t    out_res;
    logic                 push_valid;
    logic                 can_push;

    // configuration registers; unused index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                tcce_pkg::CFG_ENABLE:  cfg_reg.enable  <= cfg_data[0];
                tcce_pkg::CFG_COLUMNS: cfg_reg.columns <= cfg_data;
                tcce_pkg::CFG_ROWS:    cfg_reg.rows    <= cfg_data;
                default:               cfg_reg         <= cfg_reg;
            endcase
        end
    end

    // cursor update per character transfer
    tcce_step #(
        .CELL_WIDTH  (CELL_WIDTH),
        .CELL_HEIGHT (CELL_HEIGHT)
    ) u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_char    (s_char_code),
        .can_push   (can_push),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // queued commands, one per output transfer
    tcce_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .can_push   (can_push),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_res    (out_res)
    );

    assign m_action     = out_res.action;
    assign m_pixel_x    = out_res.pixel_x;
    assign m_pixel_y    = out_res.pixel_y;
    assign m_glyph_code = out_res.glyph_code;
    assign m_last       = out_res.last;

endmodule

[tb/sv/console_cmd_checker.sv]
// checker for the cursor engine: tracks the cursor, predicts display commands, compares them
`timescale 1ns / 100ps

module console_cmd_checker #(
    parameter int CELL_WIDTH  = 18,
    parameter int CELL_HEIGHT = 18
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcce_pkg::GRID_W-1:0]     cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [tcce_pkg::CHAR_W-1:0]     s_char_code,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_action,
    input  logic [tcce_pkg::PIXEL_W-1:0]    m_pixel_x,
    input  logic [tcce_pkg::PIXEL_W-1:0]    m_pixel_y,
    input  logic [tcce_pkg::CHAR_W-1:0]     m_glyph_code,
    input  logic                            m_last,
    output int                              mismatch_count,
    output int                              cmds_pending
);

    tcce_pkg::result_t            expected_cmds[$];
    logic                         enable_q;
    logic [tcce_pkg::GRID_W-1:0]  columns_q;
    logic [tcce_pkg::GRID_W-1:0]  rows_q;
    logic [tcce_pkg::GRID_W-1:0]  cur_row;
    logic [tcce_pkg::GRID_W-1:0]  cur_col;

    // pixel origin of a cell, saturated at the top of the pixel range
    function automatic logic [tcce_pkg::PIXEL_W-1:0] cell_origin(input int cell_idx,
                                                                 input int size);
        int p;
        p = cell_idx * size;
        if (p > int'(tcce_pkg::PIXEL_MAX))
            return tcce_pkg::PIXEL_MAX;
        return p[tcce_pkg::PIXEL_W-1:0];
    endfunction

    function automatic tcce_pkg::result_t make_cmd(
        input tcce_pkg::action_t             act,
        input logic [tcce_pkg::PIXEL_W-1:0]  x,
        input logic [tcce_pkg::PIXEL_W-1:0]  y,
        input logic [tcce_pkg::CHAR_W-1:0]   glyph);
        tcce_pkg::result_t c;
        c.action     = act;
        c.pixel_x    = x;
        c.pixel_y    = y;
        c.glyph_code = glyph;
        c.last       = 1'b0;
        return c;
    endfunction

    // advance the cursor for one character and queue the commands it causes
    function automatic void predict_commands(input logic [tcce_pkg::CHAR_W-1:0] ch);
        tcce_pkg::result_t cmds [2];
        int      n;
        bit      new_line;
        bit      moved;
        n        = 0;
        new_line = 1'b0;
        moved    = 1'b0;
        if (!enable_q || columns_q == 0 || rows_q == 0)
            return;
        case (ch)
            tcce_pkg::CHAR_LF: new_line = 1'b1;
            tcce_pkg::CHAR_CR: cur_col = '0;
            tcce_pkg::CHAR_BS, tcce_pkg::CHAR_DEL: begin
                if (cur_col != 0) begin
                    cur_col = cur_col - 1'b1;
                    moved   = 1'b1;
                end else if (cur_row != 0) begin
                    cur_row = cur_row - 1'b1;
                    cur_col = columns_q - 1'b1;
                    moved   = 1'b1;
                end
                if (moved) begin
                    cmds[n] = make_cmd(tcce_pkg::ACT_DRAW, cell_origin(cur_col, CELL_WIDTH),
                                       cell_origin(cur_row, CELL_HEIGHT),
                                       tcce_pkg::CHAR_BLANK);
                    n++;
                end
            end
            default: begin
                cmds[n] = make_cmd(tcce_pkg::ACT_DRAW, cell_origin(cur_col, CELL_WIDTH),
                                   cell_origin(cur_row, CELL_HEIGHT), ch);
                n++;
                if (int'(cur_col) + 1 >= int'(columns_q))
                    new_line = 1'b1;
                else
                    cur_col = cur_col + 1'b1;
            end
        endcase
        if (new_line) begin
            cur_col = '0;
            // at or past the last row: scroll and stay on the last row
            if (int'(cur_row) + 1 >= int'(rows_q)) begin
                cmds[n] = make_cmd(tcce_pkg::ACT_SCROLL, '0, '0, '0);
                n++;
                cur_row = rows_q - 1'b1;
            end else begin
                cur_row = cur_row + 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            cmds[i].last = (i == n - 1);
            expected_cmds.push_back(cmds[i]);
        end
    endfunction

    always @(posedge aclk) begin
        tcce_pkg::result_t got;
        tcce_pkg::result_t want;
        if (!aresetn) begin
            expected_cmds.delete();
            enable_q  = 1'b0;
            columns_q = '0;
            rows_q    = '0;
            cur_row   = '0;
            cur_col   = '0;
        end else begin
            // older commands leave before the new character is predicted
            if (m_valid && m_ready) begin
                got.action     = tcce_pkg::action_t'(m_action);
                got.pixel_x    = m_pixel_x;
                got.pixel_y    = m_pixel_y;
                got.glyph_code = m_glyph_code;
                got.last       = m_last;
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected command: action=%0d x=%0d y=%0d glyph=%02h %s=%0d",
                             $time, got.action, got.pixel_x, got.pixel_y, got.glyph_code,
                             "last", got.last);
                    mismatch_count++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got !== want) begin
                        $display("%0t: command mismatch: expected action=%0d x=%0d y=%0d %s",
                                 $time, want.action, want.pixel_x, want.pixel_y,
                                 $sformatf("glyph=%02h last=%0d", want.glyph_code,
                                           want.last));
                        $display("%0t:                   actual   action=%0d x=%0d y=%0d %s",
                                 $time, got.action, got.pixel_x, got.pixel_y,
                                 $sformatf("glyph=%02h last=%0d", got.glyph_code,
                                           got.last));
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_commands(s_char_code);
            if (cfg_we) begin
                case (cfg_index)
                    tcce_pkg::CFG_ENABLE:  enable_q  = cfg_data[0];
                    tcce_pkg::CFG_COLUMNS: columns_q = cfg_data;
                    tcce_pkg::CFG_ROWS:    rows_q    = cfg_data;
                    default: ;
                endcase
            end
        end
        cmds_pending = expected_cmds.size();
    end

endmodule

[tb/sv/testbench.sv]
// testbench top for the cursor engine: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;

    localparam int CELL_WIDTH    = 18;
    localparam int CELL_HEIGHT   = 18;
    // cycles allowed after the last command for characters that make none
    localparam int SETTLE_CYCLES = 8;
    // counted random characters that reach the cursor logic
    localparam int RANDOM_ITEMS  = 1250;
    // length of the forced receiver hold-off
    localparam int HOLD_OFF_CYCLES = 400;

    logic                               aclk         = 1'b0;
    logic                               aresetn      = 1'b0;
    logic                               cfg_we       = 1'b0;
    logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index    = tcce_pkg::CFG_ENABLE;
    logic [tcce_pkg::GRID_W-1:0]        cfg_data     = '0;
    logic                               s_valid      = 1'b0;
    logic                               s_ready;
    logic [tcce_pkg::CHAR_W-1:0]        s_char_code  = '0;
    logic                               m_valid;
    logic                               m_ready      = 1'b0;
    logic                               m_action;
    logic [tcce_pkg::PIXEL_W-1:0]       m_pixel_x;
    logic [tcce_pkg::PIXEL_W-1:0]       m_pixel_y;
    logic [tcce_pkg::CHAR_W-1:0]        m_glyph_code;
    logic                               m_last;

    int mismatch_count;
    int cmds_pending;

    // idle percentages for the current phase
    int send_idle_pct = 0;
    int stall_pct     = 0;
    // hold-off requests from the stimulus and the ones the receiver has taken
    int hold_off_reqs = 0;
    int hold_off_done = 0;
    // remaining cycles of a forced receiver hold-off
    int hold_off_len  = 0;

    text_console_cursor_engine_top #(
        .CELL_WIDTH  (CELL_WIDTH),
        .CELL_HEIGHT (CELL_HEIGHT)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_action     (m_action),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_glyph_code (m_glyph_code),
        .m_last       (m_last)
    );

    console_cmd_checker #(
        .CELL_WIDTH  (CELL_WIDTH),
        .CELL_HEIGHT (CELL_HEIGHT)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_action       (m_action),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_glyph_code   (m_glyph_code),
        .m_last         (m_last),
        .mismatch_count (mismatch_count),
        .cmds_pending   (cmds_pending)
    );

    // 50 MHz clock
    always #10 aclk = ~aclk;

    // receiver: random stalls, or a long hold-off that fills the engine and
    // backs up the character input
    always @(posedge aclk) begin
        if (hold_off_len != 0) begin
            m_ready      <= 1'b0;
            hold_off_len <= hold_off_len - 1;
        end else if (hold_off_done != hold_off_reqs) begin
            m_ready       <= 1'b0;
            hold_off_done <= hold_off_reqs;
            hold_off_len  <= HOLD_OFF_CYCLES - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // safety net against a hung handshake
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // offer one character and hold it until the transfer; valid stays high
    // into the next character unless an idle gap is taken first
    task automatic send_char(input logic [tcce_pkg::CHAR_W-1:0] ch);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_char_code <= ch;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending, wait for every predicted command, then let any
    // command-less character still in flight work its way through
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (cmds_pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all three registers back to back while the engine is idle
    task automatic load_config(input logic en, input logic [tcce_pkg::GRID_W-1:0] cols,
                               input logic [tcce_pkg::GRID_W-1:0] rows);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= tcce_pkg::CFG_ENABLE;
        cfg_data  <= {{(tcce_pkg::GRID_W-1){1'b0}}, en};
        @(posedge aclk);
        cfg_index <= tcce_pkg::CFG_COLUMNS;
        cfg_data  <= cols;
        @(posedge aclk);
        cfg_index <= tcce_pkg::CFG_ROWS;
        cfg_data  <= rows;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // mostly printable text with a fair share of control bytes, plus
    // full-range bytes so every bit of the code toggles
    function automatic logic [tcce_pkg::CHAR_W-1:0] random_char();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return tcce_pkg::CHAR_LF;
        if (r < 18)
            return tcce_pkg::CHAR_CR;
        if (r < 24)
            return tcce_pkg::CHAR_BS;
        if (r < 28)
            return tcce_pkg::CHAR_DEL;
        if (r < 40)
            return tcce_pkg::CHAR_W'($urandom_range(255));
        return tcce_pkg::CHAR_W'($urandom_range(126, 32));
    endfunction

    initial begin
        int                           counted;
        int                           phase;
        int                           n_items;
        int                           pick;
        bit                           active;
        logic                         en;
        logic [tcce_pkg::GRID_W-1:0]  cols;
        logic [tcce_pkg::GRID_W-1:0]  rows;

        counted = 0;
        phase   = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        // registers still at reset: everything is dropped
        send_char("A");
        send_char(tcce_pkg::CHAR_LF);

        // 3 x 2 grid
        load_config(1'b1, 8'd3, 8'd2);
        send_char(tcce_pkg::CHAR_BS);      // backspace at the home cell, no command
        send_char("A");
        send_char("B");
        send_char("C");                    // end of row wraps to the next row
        send_char("D");
        send_char(tcce_pkg::CHAR_BS);      // erase within the row
        send_char(tcce_pkg::CHAR_BS);      // wraps back to the end of the previous row
        send_char(tcce_pkg::CHAR_DEL);
        send_char(tcce_pkg::CHAR_CR);
        send_char(tcce_pkg::CHAR_LF);      // newline without scroll
        send_char(tcce_pkg::CHAR_LF);      // newline on the last row scrolls
        send_char(8'h00);
        send_char(8'hFF);
        send_char("X");                    // end of the last row: draw and scroll
        send_char("Y");
        send_char("Z");

        // shrink the grid under the cursor: draw outside, then scroll back in
        load_config(1'b1, 8'd1, 8'd1);
        send_char("Q");
        send_char("R");

        // largest grid
        load_config(1'b1, 8'd255, 8'd255);
        send_char(8'h55);
        send_char(8'hAA);
        send_char(tcce_pkg::CHAR_LF);
        send_char(tcce_pkg::CHAR_DEL);

        // zero-size grid in either direction is ignored
        load_config(1'b1, 8'd0, 8'd5);
        send_char("a");
        load_config(1'b1, 8'd5, 8'd0);
        send_char("b");

        // random part: phases rotate through the idle patterns and pick random grid shapes
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(15);
            en   = 1'b1;
            case (pick)
                0: begin
                    en   = 1'b0;
                    cols = tcce_pkg::GRID_W'($urandom_range(255));
                    rows = tcce_pkg::GRID_W'($urandom_range(255));
                end
                1: begin
                    cols = $urandom_range(1) ? 8'd0 : tcce_pkg::GRID_W'($urandom_range(255));
                    rows = (cols == 0) ? tcce_pkg::GRID_W'($urandom_range(255)) : 8'd0;
                end
                2: begin
                    cols = 8'd255;
                    rows = 8'd255;
                end
                3: begin
                    cols = 8'd1;
                    rows = tcce_pkg::GRID_W'($urandom_range(1, 3));
                end
                4: begin
                    cols = tcce_pkg::GRID_W'($urandom_range(1, 3));
                    rows = 8'd1;
                end
                5: begin
                    cols = tcce_pkg::GRID_W'($urandom_range(1, 255));
                    rows = tcce_pkg::GRID_W'($urandom_range(1, 255));
                end
                default: begin
                    cols = tcce_pkg::GRID_W'($urandom_range(1, 8));
                    rows = tcce_pkg::GRID_W'($urandom_range(1, 6));
                end
            endcase
            // the pressure phase needs a live grid so commands pile up
            if (phase == 4) begin
                en   = 1'b1;
                cols = 8'd2;
                rows = 8'd2;
            end
            load_config(en, cols, rows);

            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1: begin
                    send_idle_pct = 80;
                    stall_pct    <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct    <= 80;
                end
                default: begin
                    send_idle_pct = 9;
                    stall_pct    <= 9;
                end
            endcase
            // long receiver hold-off while the sender keeps going
            if (phase == 4)
                hold_off_reqs++;

            active  = en && cols != 0 && rows != 0;
            n_items = active ? $urandom_range(60, 140) : 20;
            repeat (n_items) begin
                send_char(random_char());
                if (active)
                    counted++;
            end
            phase++;
        end

        settle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[text_console_cursor_engine_top.f]
hdl/tcce_pkg.sv
hdl/tcce_step.sv
hdl/tcce_result_queue.sv
hdl/text_console_cursor_engine_top.sv
tb/sv/console_cmd_checker.sv
tb/sv/testbench.sv
